FILE: sv/grwh_pkg.sv
`default_nettype none
package grwh_pkg;

    // map and walk limits
    localparam int MAP_CELLS  = 32;
    localparam int MAX_HITS   = 64;
    localparam int DIV_STEPS  = 34;
    localparam int CLR_DEPTH  = MAP_CELLS * MAP_CELLS * 4;

    localparam logic [19:0] DIST_MAX = 20'hFFFFF;

    // face codes
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    // input actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_ADV   = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_CHK   = 10'b00_0010_0000,
        S_MEM   = 10'b00_0100_0000,
        S_SCL   = 10'b00_1000_0000,
        S_OFF   = 10'b01_0000_0000,
        S_SEL   = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        PH_INIT_V = 3'b001,
        PH_INIT_H = 3'b010,
        PH_WALK   = 3'b100
    } t_phase;

endpackage
`default_nettype wire

FILE: sv/grid_ray_wall_hit_walker_core.sv
// Grid ray wall-hit walker.
// Input channel (i_valid / o_stall) takes either a face-table write or a ray
// cast. Output channel (o_valid / i_stall) returns result beats; o_last marks
// the final beat of an item. A write returns one acknowledge beat the cycle
// after it is accepted. A cast returns its wall hits nearest first, or one
// beat with o_hit_valid low when nothing is hit; at most 64 hits per ray.
// One item at a time: a new item is taken only in idle. A cast walks each
// cell-boundary crossing with one pass of the 34-step shared restoring
// divider plus a check and a table read; a crossing that holds a wall adds
// a second divider pass, the perspective multiply and the offset, and each
// hit is then picked in its own step.
// Reset: map size registers return to 32x32 and a clearing pass over all 4096
// entries empties the face table, one entry a cycle; o_stall stays high until
// it ends. Configuration writes are taken at any time.
// Stall: the output register holds its beat while i_stall is high; the walk
// pauses at the next hit until the output register frees.
`default_nettype none
module grid_ray_wall_hit_walker_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_action,
    input  wire logic [4:0]         i_cell_x,
    input  wire logic [4:0]         i_cell_y,
    input  wire logic [1:0]         i_face_sel,
    input  wire logic [7:0]         i_face_texture,
    input  wire logic               i_face_present,
    input  wire logic [18:0]        i_pos_x,
    input  wire logic [18:0]        i_pos_y,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic [14:0]        i_perspective_scale,
    input  wire logic signed [15:0] i_distort_offset,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [5:0]         i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit_valid,
    output logic [19:0]             o_hit_distance,
    output logic [7:0]              o_texture_index,
    output logic [5:0]              o_texel_column,
    output logic [1:0]              o_wall_face,
    output logic                    o_last
);

    grwh_pkg::t_state r_state;
    grwh_pkg::t_phase r_phase;

    // configuration
    logic [5:0] r_map_w, r_map_h;

    // ray registers
    logic [18:0]        r_px, r_py;
    logic signed [15:0] r_dx, r_dy, r_off;
    logic [14:0]        r_ps;

    // trackers: index 0 vertical, 1 horizontal
    logic               r_alive [2];
    logic signed [6:0]  r_k     [2];
    logic signed [36:0] r_dist  [2];
    logic [7:0]         r_tex   [2];
    logic [5:0]         r_col   [2];
    logic               r_sel;

    // shared datapath
    logic signed [21:0] r_diff;
    logic               r_sgn;
    logic               r_kind_raw;
    logic [33:0]        r_quo;
    logic [15:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [48:0]        r_scaled;

    // clearing pass, hit count, held hit
    logic [11:0] r_clr;
    logic [6:0]  r_n;
    logic        r_h_v;
    logic [19:0] r_h_dist;
    logic [7:0]  r_h_tex;
    logic [5:0]  r_h_col;
    logic [1:0]  r_h_face;

    // output register
    logic        r_o_valid, r_o_hit, r_o_last;
    logic [19:0] r_o_dist;
    logic [7:0]  r_o_tex;
    logic [5:0]  r_o_col;
    logic [1:0]  r_o_face;

    // face table
    logic [8:0]  mem [grwh_pkg::CLR_DEPTH];
    logic [8:0]  r_rd;
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [8:0]  mem_wdata;

    logic               out_free, in_acc;
    logic [5:0]         lim_w, lim_h, lim_a, lim_b;
    logic signed [15:0] t_d, t_o;
    logic [18:0]        t_p, t_po;
    logic signed [6:0]  t_k;
    logic               neg_d;
    logic [15:0]        dmag;
    logic signed [7:0]  cell_a;
    logic               a_ok, b_ok;
    logic signed [21:0] diff_w, diff_mag;
    logic signed [37:0] prod_w, prod_mag;
    logic [16:0]        dv_tmp;
    logic               dv_ge;
    logic signed [35:0] q_w, vd_w;
    logic [4:0]         cell_b;
    logic [1:0]         face_v, face_h, face_t;
    logic signed [36:0] dist_w;
    logic               more, pick_h;
    logic signed [36:0] pick_dist;
    logic [19:0]        pick_sat;
    grwh_pkg::t_state   fin_state;
    grwh_pkg::t_phase   fin_phase;
    logic               fin_sel;

    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = !((r_state == grwh_pkg::S_IDLE) && out_free);
    assign in_acc   = i_valid && !o_stall;

    // clip map size to the table
    assign lim_w = (r_map_w > 6'(grwh_pkg::MAP_CELLS)) ? 6'(grwh_pkg::MAP_CELLS) : r_map_w;
    assign lim_h = (r_map_h > 6'(grwh_pkg::MAP_CELLS)) ? 6'(grwh_pkg::MAP_CELLS) : r_map_h;

    // select operands of the active tracker
    always_comb begin
        t_d   = r_sel ? r_dy : r_dx;
        t_o   = r_sel ? r_dx : r_dy;
        t_p   = r_sel ? r_py : r_px;
        t_po  = r_sel ? r_px : r_py;
        t_k   = r_sel ? r_k[1] : r_k[0];
        lim_a = r_sel ? lim_h : lim_w;
        lim_b = r_sel ? lim_w : lim_h;
    end

    assign neg_d  = t_d[15];
    assign dmag   = neg_d ? 16'(-t_d) : {1'b0, t_d[14:0]};
    assign face_v = r_dx[15] ? grwh_pkg::FACE_EAST : grwh_pkg::FACE_WEST;
    assign face_h = r_dy[15] ? grwh_pkg::FACE_SOUTH : grwh_pkg::FACE_NORTH;
    assign face_t = r_sel ? face_h : face_v;

    // boundary cell and distance along the walked axis
    assign cell_a = $signed({t_k[6], t_k}) - $signed({7'd0, neg_d});
    assign a_ok   = !cell_a[7] && (cell_a[6:0] < {1'b0, lim_a});
    assign diff_w = $signed({t_k[6], t_k, 14'd0}) - $signed({3'd0, t_p});
    assign diff_mag = r_diff[21] ? -r_diff : r_diff;

    // cross product for the other coordinate
    assign prod_w   = t_o * r_diff;
    assign prod_mag = prod_w[37] ? -prod_w : prod_w;

    // one restoring divide step
    assign dv_tmp = {r_rem, r_quo[33]};
    assign dv_ge  = dv_tmp >= {1'b0, dmag};

    // other coordinate and its cell
    assign q_w    = r_sgn ? -$signed({2'd0, r_quo}) : $signed({2'd0, r_quo});
    assign vd_w   = $signed({17'd0, t_po}) + q_w;
    assign b_ok   = !vd_w[35] && (vd_w[34:14] < 21'(lim_b));
    assign cell_b = vd_w[18:14];

    assign dist_w = $signed({2'd0, r_scaled[48:14]}) + $signed({{21{r_off[15]}}, r_off});

    // nearest-first pick, ties to horizontal
    assign pick_h = !(r_alive[0] && (!r_alive[1] || (r_dist[0] < r_dist[1])));
    assign pick_dist = pick_h ? r_dist[1] : r_dist[0];
    always_comb begin
        if (pick_dist[36]) begin
            pick_sat = 20'd0;
        end else if (|pick_dist[35:20]) begin
            pick_sat = grwh_pkg::DIST_MAX;
        end else begin
            pick_sat = pick_dist[19:0];
        end
    end
    assign more = (r_alive[0] || r_alive[1]) && (r_n != 7'(grwh_pkg::MAX_HITS));

    // where a tracker advance returns to
    always_comb begin
        case (r_phase)
            grwh_pkg::PH_INIT_V: begin
                fin_state = grwh_pkg::S_ADV;
                fin_phase = grwh_pkg::PH_INIT_H;
                fin_sel   = 1'b1;
            end
            default: begin
                fin_state = grwh_pkg::S_SEL;
                fin_phase = grwh_pkg::PH_WALK;
                fin_sel   = r_sel;
            end
        endcase
    end

    // table ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 9'd0;
        if (r_state == grwh_pkg::S_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && (i_action == grwh_pkg::ACT_WRITE)) begin
            mem_we    = 1'b1;
            mem_waddr = {i_cell_y, i_cell_x, i_face_sel};
            mem_wdata = i_face_present ? {1'b1, i_face_texture} : 9'd0;
        end
        mem_raddr = r_sel ? {cell_a[4:0], cell_b, face_t} : {cell_b, cell_a[4:0], face_t};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 6'(grwh_pkg::MAP_CELLS);
            r_map_h <= 6'(grwh_pkg::MAP_CELLS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grwh_pkg::CFG_WIDTH:  r_map_w <= i_cfg_data;
                grwh_pkg::CFG_HEIGHT: r_map_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= grwh_pkg::S_CLEAR;
            r_phase    <= grwh_pkg::PH_INIT_V;
            r_clr      <= 12'd0;
            r_alive[0] <= 1'b0;
            r_alive[1] <= 1'b0;
            r_sel      <= 1'b0;
            r_n        <= 7'd0;
            r_h_v      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cnt      <= 6'd0;
            r_kind_raw <= 1'b0;
        end else begin
            // drop a beat that was taken
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                grwh_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 12'd1;
                    if (r_clr == 12'(grwh_pkg::CLR_DEPTH - 1)) begin
                        r_state <= grwh_pkg::S_IDLE;
                    end
                end
                grwh_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_action == grwh_pkg::ACT_WRITE) begin
                            r_o_valid <= 1'b1;
                            r_o_hit   <= 1'b0;
                            r_o_dist  <= 20'd0;
                            r_o_tex   <= 8'd0;
                            r_o_col   <= 6'd0;
                            r_o_face  <= 2'd0;
                            r_o_last  <= 1'b1;
                        end else begin
                            r_px       <= i_pos_x;
                            r_py       <= i_pos_y;
                            r_dx       <= i_dir_x;
                            r_dy       <= i_dir_y;
                            r_ps       <= i_perspective_scale;
                            r_off      <= i_distort_offset;
                            r_k[0]     <= $signed({2'd0, i_pos_x[18:14]})
                                          + $signed({6'd0, ~i_dir_x[15]});
                            r_k[1]     <= $signed({2'd0, i_pos_y[18:14]})
                                          + $signed({6'd0, ~i_dir_y[15]});
                            r_alive[0] <= (i_dir_x != 16'sd0);
                            r_alive[1] <= (i_dir_y != 16'sd0);
                            r_n        <= 7'd0;
                            r_h_v      <= 1'b0;
                            r_sel      <= 1'b0;
                            r_phase    <= grwh_pkg::PH_INIT_V;
                            r_state    <= grwh_pkg::S_ADV;
                        end
                    end
                end
                grwh_pkg::S_ADV: begin
                    // check the crossed boundary cell along the walked axis
                    if (!(r_sel ? r_alive[1] : r_alive[0])) begin
                        r_state <= fin_state;
                        r_phase <= fin_phase;
                        r_sel   <= fin_sel;
                    end else if (!a_ok) begin
                        r_alive[r_sel] <= 1'b0;
                        r_state <= fin_state;
                        r_phase <= fin_phase;
                        r_sel   <= fin_sel;
                    end else begin
                        r_diff  <= diff_w;
                        r_state <= grwh_pkg::S_MUL;
                    end
                end
                grwh_pkg::S_MUL: begin
                    // start divide for the other coordinate
                    r_sgn      <= prod_w[37] ^ neg_d;
                    r_quo      <= prod_mag[33:0];
                    r_rem      <= 16'd0;
                    r_cnt      <= 6'd0;
                    r_kind_raw <= 1'b0;
                    r_state    <= grwh_pkg::S_DIV;
                end
                grwh_pkg::S_DIV: begin
                    r_rem <= dv_ge ? 16'(dv_tmp - {1'b0, dmag}) : dv_tmp[15:0];
                    r_quo <= {r_quo[32:0], dv_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(grwh_pkg::DIV_STEPS - 1)) begin
                        r_state <= r_kind_raw ? grwh_pkg::S_SCL : grwh_pkg::S_CHK;
                    end
                end
                grwh_pkg::S_CHK: begin
                    // bound check, table read, step the boundary
                    if (!b_ok) begin
                        r_alive[r_sel] <= 1'b0;
                        r_state <= fin_state;
                        r_phase <= fin_phase;
                        r_sel   <= fin_sel;
                    end else begin
                        r_col[r_sel] <= vd_w[13:8];
                        r_k[r_sel]   <= neg_d ? t_k - 7'sd1 : t_k + 7'sd1;
                        r_state      <= grwh_pkg::S_MEM;
                    end
                end
                grwh_pkg::S_MEM: begin
                    if (r_rd[8]) begin
                        r_tex[r_sel] <= r_rd[7:0];
                        r_quo      <= {diff_mag[19:0], 14'd0};
                        r_rem      <= 16'd0;
                        r_cnt      <= 6'd0;
                        r_kind_raw <= 1'b1;
                        r_state    <= grwh_pkg::S_DIV;
                    end else begin
                        r_state <= grwh_pkg::S_ADV;
                    end
                end
                grwh_pkg::S_SCL: begin
                    r_scaled <= r_quo * r_ps;
                    r_state  <= grwh_pkg::S_OFF;
                end
                grwh_pkg::S_OFF: begin
                    r_dist[r_sel] <= dist_w;
                    r_state <= fin_state;
                    r_phase <= fin_phase;
                    r_sel   <= fin_sel;
                end
                grwh_pkg::S_SEL: begin
                    if (more) begin
                        // hold the nearest hit until the next one is known
                        if (!r_h_v || out_free) begin
                            if (r_h_v) begin
                                r_o_valid <= 1'b1;
                                r_o_hit   <= 1'b1;
                                r_o_dist  <= r_h_dist;
                                r_o_tex   <= r_h_tex;
                                r_o_col   <= r_h_col;
                                r_o_face  <= r_h_face;
                                r_o_last  <= 1'b0;
                            end
                            r_h_v    <= 1'b1;
                            r_h_dist <= pick_sat;
                            r_h_tex  <= pick_h ? r_tex[1] : r_tex[0];
                            r_h_col  <= pick_h ? r_col[1] : r_col[0];
                            r_h_face <= pick_h ? face_h : face_v;
                            r_n      <= r_n + 7'd1;
                            r_sel    <= pick_h;
                            r_state  <= grwh_pkg::S_ADV;
                        end
                    end else if (out_free) begin
                        // final beat: held hit or an empty result
                        r_o_valid <= 1'b1;
                        r_o_hit   <= r_h_v;
                        r_o_dist  <= r_h_v ? r_h_dist : 20'd0;
                        r_o_tex   <= r_h_v ? r_h_tex : 8'd0;
                        r_o_col   <= r_h_v ? r_h_col : 6'd0;
                        r_o_face  <= r_h_v ? r_h_face : 2'd0;
                        r_o_last  <= 1'b1;
                        r_h_v     <= 1'b0;
                        r_state   <= grwh_pkg::S_IDLE;
                    end
                end
                default: r_state <= grwh_pkg::S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_hit_valid     = r_o_hit;
    assign o_hit_distance  = r_o_dist;
    assign o_texture_index = r_o_tex;
    assign o_texel_column  = r_o_col;
    assign o_wall_face     = r_o_face;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire

FILE: sv/grwh_checker.sv
`default_nettype none
module grwh_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               i_action,
    input wire logic [4:0]         i_cell_x,
    input wire logic [4:0]         i_cell_y,
    input wire logic [1:0]         i_face_sel,
    input wire logic [7:0]         i_face_texture,
    input wire logic               i_face_present,
    input wire logic [18:0]        i_pos_x,
    input wire logic [18:0]        i_pos_y,
    input wire logic signed [15:0] i_dir_x,
    input wire logic signed [15:0] i_dir_y,
    input wire logic [14:0]        i_perspective_scale,
    input wire logic signed [15:0] i_distort_offset,
    input wire logic               i_cfg_we,
    input wire logic               i_cfg_idx,
    input wire logic [5:0]         i_cfg_data,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_hit_valid,
    input wire logic [19:0]        o_hit_distance,
    input wire logic [7:0]         o_texture_index,
    input wire logic [5:0]         o_texel_column,
    input wire logic [1:0]         o_wall_face,
    input wire logic               o_last
);

    logic [6:0] r_beats;

    // count non-final beats of the current item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= 7'd0;
        end else if (o_valid && !i_stall) begin
            r_beats <= o_last ? 7'd0 : r_beats + 7'd1;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("beat right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit_distance) && $stable(o_last))
        else $error("stalled beat changed");

    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_valid |-> o_last) else $error("non-hit beat not last");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_valid |-> o_hit_distance == 20'd0 && o_texture_index == 8'd0
            && o_texel_column == 6'd0 && o_wall_face == 2'd0)
        else $error("non-hit beat carries data");

    a_hit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> r_beats < 7'(grwh_pkg::MAX_HITS - 1))
        else $error("too many hits for one ray");

endmodule

bind grid_ray_wall_hit_walker_core grwh_checker u_grwh_checker (.*);
`default_nettype wire
